>>> src/battery_cell_discharge_model_defines.svh
// Assertion macros shared by the checker of the battery cell emulator.
`ifndef BATTERY_CELL_DISCHARGE_MODEL_DEFINES_SVH
`define BATTERY_CELL_DISCHARGE_MODEL_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BCDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bcdm_pkg.sv
package bcdm_pkg;

  localparam int CHARGE_BITS = 48;
  localparam int CAP_W       = 38;
  localparam int NUM_W       = 61;
  localparam int QUO_W       = 24;
  localparam int IN_W        = 40;
  localparam int OUT_W       = 56;
  localparam int ADDR_W      = 5;

  localparam logic [21:0] MAS_PER_MAH = 22'd3600000;

  localparam logic [2:0] REG_CAPACITY  = 3'd0;
  localparam logic [2:0] REG_INIT_VOLT = 3'd1;
  localparam logic [2:0] REG_SHIFT_LO  = 3'd2;
  localparam logic [2:0] REG_SHIFT_HI  = 3'd3;
  localparam logic [2:0] REG_DROP_LO   = 3'd4;
  localparam logic [2:0] REG_DROP_HI   = 3'd5;

  localparam logic [1:0] SEG_LOW  = 2'd0;
  localparam logic [1:0] SEG_MID  = 2'd1;
  localparam logic [1:0] SEG_HIGH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_CHK, S_DIVX, S_DIVR, S_SEG, S_DIVQ, S_VMUL, S_VFIN, S_OUT
  } state_e;

endpackage

>>> src/battery_cell_discharge_model.sv
// A request passes through update and check steps, three 24-step passes of the shared
// restoring divider, a segment step and the voltage steps before its result is valid.
// An exhausted cell skips the divider.
// The block takes a new request only after the last result has entered the output
// register, so a stalled result holds off the next request. Input tready is low while a
// request is worked on.
// Reset (asynchronous, active low) clears the charge, current and segment state and
// loads the default cell registers; no clearing pass is needed.
module battery_cell_discharge_model (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: connected[0], load_current_ma[16:1], duration_ms[32:17], zero pad
  input  logic [bcdm_pkg::IN_W-1:0]   s_axis_tdata,
  // tuser: kind (0 discharge update, 1 reload)
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: accepted[0], voltage_mv[16:1], remaining_hundredths[30:17],
  // source_current_ma[46:31], segment[48:47], exhausted[49], zero pad
  output logic [bcdm_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcdm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bcdm_pkg::*;

  // Cell registers written over the configuration port.
  logic [15:0] cap_q, v0_q;
  logic [6:0]  sl_q, sh_q, dl_q, dh_q;

  // Sequencer and datapath registers.
  state_e state_q, state_d;
  logic [CHARGE_BITS-1:0] chg_q, chg_d;
  logic [15:0] cur_q, cur_d;
  logic [1:0]  seg_q, seg_d;
  logic        kind_q, conn_q, ok_q, ok_d, exh_q, exh_d, neg_q, neg_d;
  logic [15:0] in_cur_q, in_dur_q;
  logic [CAP_W-1:0] c_q, c_d;
  logic [22:0] x_q, x_d, base_q, base_d;
  logic [13:0] rem_q, rem_d;
  logic [15:0] volt_q, volt_d;
  logic signed [25:0] dq_q, dq_d;
  logic signed [42:0] vprod_q, vprod_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        m_valid_q, m_valid_d;
  logic [OUT_W-1:0] m_data_q, m_data_d;

  // Shared restoring divider: partial remainder and shifting numerator/quotient.
  logic [CAP_W-1:0] dv_part_q, dv_part_d, dv_den_q, dv_den_d;
  logic [QUO_W-1:0] dv_lo_q, dv_lo_d;
  logic [CAP_W:0]   dv_t, dv_sub;
  logic             dv_ge;
  logic [CAP_W-1:0] dv_part_step;
  logic [QUO_W-1:0] dv_lo_step;

  assign dv_t         = {dv_part_q, dv_lo_q[QUO_W-1]};
  assign dv_sub       = dv_t - {1'b0, dv_den_q};
  assign dv_ge        = dv_t >= {1'b0, dv_den_q};
  assign dv_part_step = dv_ge ? dv_sub[CAP_W-1:0] : dv_t[CAP_W-1:0];
  assign dv_lo_step   = {dv_lo_q[QUO_W-2:0], dv_ge};

  // Full capacity in mA*ms and the two wide numerators, built from shifts and adds.
  logic [CAP_W-1:0] cap_full, d_lo, c_minus_d;
  logic [NUM_W-1:0] num_x, num_r, num_q;
  logic             is_exh;
  logic [CHARGE_BITS:0] chg_sum;

  assign cap_full  = CAP_W'(cap_q) * CAP_W'(MAS_PER_MAH);
  assign d_lo      = chg_q[CAP_W-1:0];
  assign c_minus_d = c_q - d_lo;
  assign is_exh    = chg_q >= {{(CHARGE_BITS-CAP_W){1'b0}}, c_q};
  // D * 6553600 = D * 100 * 65536
  assign num_x = (NUM_W'(d_lo) << 22) + (NUM_W'(d_lo) << 21) + (NUM_W'(d_lo) << 18);
  // (C - D) * 10000
  assign num_r = (NUM_W'(c_minus_d) << 13) + (NUM_W'(c_minus_d) << 10)
               + (NUM_W'(c_minus_d) << 9) + (NUM_W'(c_minus_d) << 8)
               + (NUM_W'(c_minus_d) << 4);
  assign chg_sum = {1'b0, chg_q}
                 + (CHARGE_BITS+1)'({16'b0, in_cur_q} * {16'b0, in_dur_q});

  // Segment choice from the discharged percent x (Q16) and the drop numerator.
  logic [1:0]        seg_sel;
  logic signed [7:0] fac;
  logic [6:0]        fac_mag, den7;
  logic [22:0]       diff, base_sel;
  logic [29:0]       prod_mag;

  always_comb begin
    if ({1'b0, x_q} < {1'b0, sl_q, 16'b0}) begin
      seg_sel  = SEG_LOW;
      fac      = $signed({1'b0, dl_q});
      diff     = x_q;
      den7     = sl_q;
      base_sel = '0;
    end else if ({1'b0, x_q} < {1'b0, sh_q, 16'b0}) begin
      seg_sel  = SEG_MID;
      fac      = $signed({1'b0, dh_q}) - $signed({1'b0, dl_q});
      diff     = x_q - {sl_q, 16'b0};
      den7     = sh_q - sl_q;
      base_sel = {dl_q, 16'b0};
    end else begin
      seg_sel  = SEG_HIGH;
      fac      = 8'sd100 - $signed({1'b0, dh_q});
      diff     = x_q - {sh_q, 16'b0};
      den7     = 7'd100 - sh_q;
      base_sel = {dh_q, 16'b0};
    end
  end

  assign fac_mag  = fac[7] ? 7'(-fac) : fac[6:0];
  assign prod_mag = 30'(fac_mag) * 30'(diff);
  assign num_q    = NUM_W'(prod_mag);

  // Voltage: dq = base +/- quotient, then V0 - trunc(V0 * dq / 65536), saturated.
  logic signed [25:0] q_signed, dq_new;
  logic signed [42:0] vprod_new, vprod_adj;
  logic signed [26:0] vtr;
  logic signed [28:0] vres;

  assign q_signed  = $signed({3'b0, dv_lo_q[22:0]});
  assign dq_new    = $signed({3'b0, base_q}) + (neg_q ? -q_signed : q_signed);
  assign vprod_new = $signed({27'b0, v0_q}) * 43'(dq_q);
  assign vprod_adj = vprod_q[42] ? vprod_q + 43'sd65535 : vprod_q;
  assign vtr       = 27'(vprod_adj >>> 16);
  assign vres      = $signed({13'b0, v0_q}) - 29'(vtr);

  // Configuration port: writes complete in the access phase, reads return the register.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      REG_CAPACITY:  prdata = {16'b0, cap_q};
      REG_INIT_VOLT: prdata = {16'b0, v0_q};
      REG_SHIFT_LO:  prdata = {25'b0, sl_q};
      REG_SHIFT_HI:  prdata = {25'b0, sh_q};
      REG_DROP_LO:   prdata = {25'b0, dl_q};
      REG_DROP_HI:   prdata = {25'b0, dh_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'd800;
      v0_q  <= 16'd12000;
      sl_q  <= 7'd10;
      sh_q  <= 7'd85;
      dl_q  <= 7'd5;
      dh_q  <= 7'd10;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        REG_CAPACITY:  cap_q <= pwdata[15:0];
        REG_INIT_VOLT: v0_q  <= pwdata[15:0];
        REG_SHIFT_LO:  sl_q  <= pwdata[6:0];
        REG_SHIFT_HI:  sh_q  <= pwdata[6:0];
        REG_DROP_LO:   dl_q  <= pwdata[6:0];
        REG_DROP_HI:   dh_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Sequencer: one request walks through update, exhaustion check, the three
  // divisions on the shared divider, and the voltage multiply, unless the cell is exhausted.
  always_comb begin
    state_d   = state_q;
    chg_d     = chg_q;
    cur_d     = cur_q;
    seg_d     = seg_q;
    ok_d      = ok_q;
    exh_d     = exh_q;
    neg_d     = neg_q;
    c_d       = c_q;
    x_d       = x_q;
    base_d    = base_q;
    rem_d     = rem_q;
    volt_d    = volt_q;
    dq_d      = dq_q;
    vprod_d   = vprod_q;
    cnt_d     = cnt_q;
    dv_part_d = dv_part_q;
    dv_den_d  = dv_den_q;
    dv_lo_d   = dv_lo_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        ok_d = 1'b1;
        c_d  = cap_full;
        if (kind_q) begin
          chg_d = '0;
        end else if (in_dur_q == 16'd0) begin
          ok_d = 1'b0;
        end else if (!conn_q) begin
          cur_d = '0;
        end else begin
          cur_d = in_cur_q;
          // Saturate at the all-ones charge on overflow.
          chg_d = chg_sum[CHARGE_BITS] ? '1 : chg_sum[CHARGE_BITS-1:0];
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        cnt_d = '0;
        if (is_exh) begin
          volt_d  = '0;
          rem_d   = '0;
          seg_d   = SEG_HIGH;
          exh_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          exh_d     = 1'b0;
          dv_part_d = CAP_W'(num_x[NUM_W-1:QUO_W]);
          dv_lo_d   = num_x[QUO_W-1:0];
          dv_den_d  = c_q;
          state_d   = S_DIVX;
        end
      end
      S_DIVX: begin
        dv_part_d = dv_part_step;
        dv_lo_d   = dv_lo_step;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'(QUO_W-1)) begin
          x_d       = dv_lo_step[22:0];
          cnt_d     = '0;
          dv_part_d = CAP_W'(num_r[NUM_W-1:QUO_W]);
          dv_lo_d   = num_r[QUO_W-1:0];
          state_d   = S_DIVR;
        end
      end
      S_DIVR: begin
        dv_part_d = dv_part_step;
        dv_lo_d   = dv_lo_step;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'(QUO_W-1)) begin
          rem_d   = dv_lo_step[13:0];
          cnt_d   = '0;
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        seg_d     = seg_sel;
        base_d    = base_sel;
        neg_d     = fac[7];
        dv_part_d = CAP_W'(num_q[NUM_W-1:QUO_W]);
        dv_lo_d   = num_q[QUO_W-1:0];
        dv_den_d  = CAP_W'(den7);
        state_d   = S_DIVQ;
      end
      S_DIVQ: begin
        dv_part_d = dv_part_step;
        dv_lo_d   = dv_lo_step;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'(QUO_W-1)) begin
          cnt_d   = '0;
          state_d = S_VMUL;
        end
      end
      S_VMUL: begin
        dq_d    = dq_new;
        state_d = S_VFIN;
      end
      S_VFIN: begin
        vprod_d = vprod_new;
        state_d = S_OUT;
      end
      S_OUT: begin
        // First visit after S_VFIN finishes the voltage from the registered product.
        if (!exh_q) begin
          if (vres < 0) begin
            volt_d = '0;
          end else if (vres > 29'sd65535) begin
            volt_d = 16'hFFFF;
          end else begin
            volt_d = vres[15:0];
          end
        end
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'({exh_q, seg_q, cur_q, rem_q, volt_d, ok_q});
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chg_q     <= '0;
      cur_q     <= '0;
      seg_q     <= SEG_LOW;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chg_q     <= chg_d;
      cur_q     <= cur_d;
      seg_q     <= seg_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      kind_q   <= s_axis_tuser;
      conn_q   <= s_axis_tdata[0];
      in_cur_q <= s_axis_tdata[16:1];
      in_dur_q <= s_axis_tdata[32:17];
    end
    ok_q      <= ok_d;
    exh_q     <= exh_d;
    neg_q     <= neg_d;
    c_q       <= c_d;
    x_q       <= x_d;
    base_q    <= base_d;
    rem_q     <= rem_d;
    volt_q    <= volt_d;
    dq_q      <= dq_d;
    vprod_q   <= vprod_d;
    dv_part_q <= dv_part_d;
    dv_den_q  <= dv_den_d;
    dv_lo_q   <= dv_lo_d;
    m_data_q  <= m_data_d;
  end

endmodule

>>> src/bcdm_checker.sv
`include "battery_cell_discharge_model_defines.svh"

module bcdm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [bcdm_pkg::IN_W-1:0]   s_axis_tdata,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [bcdm_pkg::OUT_W-1:0]  m_axis_tdata
);
  import bcdm_pkg::*;

  // A result that is offered stays offered until it is taken.
  `BCDM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

  // The block works on one request at a time.
  `BCDM_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy not shown")

  // An exhausted cell reports zero voltage, zero remaining and the last segment.
  `BCDM_ASSERT_NOW(a_exh, m_axis_tvalid && m_axis_tdata[49], (m_axis_tdata[16:1] == 16'd0) && (m_axis_tdata[30:17] == 14'd0) && (m_axis_tdata[48:47] == SEG_HIGH), "exhausted fields")

  // Remaining capacity never exceeds one hundred percent and the segment is valid.
  `BCDM_ASSERT_NOW(a_range, m_axis_tvalid, (m_axis_tdata[30:17] <= 14'd10000) && (m_axis_tdata[48:47] != 2'd3), "result out of range")

endmodule

bind battery_cell_discharge_model bcdm_checker u_bcdm_checker (.*);

>>> verif/tb.sv
module tb;
  import bcdm_pkg::*;

  // One result of the cell emulator, in the field order of the output stream.
  typedef struct {
    bit          accepted;
    logic [15:0] voltage_mv;
    logic [13:0] remaining;
    logic [15:0] current_ma;
    logic [1:0]  segment;
    bit          exhausted;
  } cell_report_t;

  // Shadow copy of the cell: registers, discharged charge and present current.
  // Each accepted request updates it and queues the report the block must give.
  class cell_scoreboard;
    logic [15:0] cap_mah;
    logic [15:0] v0_mv;
    logic [6:0]  shift_lo, shift_hi, drop_lo, drop_hi;
    longint unsigned charge;
    logic [15:0] current_ma;
    cell_report_t pending[$];
    int errors;

    function new();
      cap_mah = 800; v0_mv = 12000;
      shift_lo = 10; shift_hi = 85; drop_lo = 5; drop_hi = 10;
      charge = 0; current_ma = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_CAPACITY:  cap_mah  = val[15:0];
        REG_INIT_VOLT: v0_mv    = val[15:0];
        REG_SHIFT_LO:  shift_lo = val[6:0];
        REG_SHIFT_HI:  shift_hi = val[6:0];
        REG_DROP_LO:   drop_lo  = val[6:0];
        REG_DROP_HI:   drop_hi  = val[6:0];
        default: ;
      endcase
    endfunction

    function void note_request(bit kind, bit conn, logic [15:0] cur, logic [15:0] dur);
      longint unsigned full_cap, add, charge_max;
      longint x, dq, v, sl, sh, dl, dh, v0;
      cell_report_t r;
      charge_max = (64'd1 << CHARGE_BITS) - 1;
      r.accepted = 1;
      if (kind) begin
        charge = 0;
      end else if (dur == 0) begin
        r.accepted = 0;
      end else if (!conn) begin
        current_ma = 0;
      end else begin
        add = longint'(cur) * longint'(dur);
        current_ma = cur;
        if (charge > charge_max - add) charge = charge_max;
        else charge = charge + add;
      end
      full_cap = longint'(cap_mah) * 64'd3600000;
      r.current_ma = current_ma;
      r.voltage_mv = 0; r.remaining = 0; r.segment = SEG_HIGH; r.exhausted = 1;
      if (charge < full_cap) begin
        sl = shift_lo; sh = shift_hi; dl = drop_lo; dh = drop_hi; v0 = v0_mv;
        r.exhausted = 0;
        r.remaining = 14'(((full_cap - charge) * 10000) / full_cap);
        x = longint'((charge * 6553600) / full_cap);
        // Exact compares pick the segment; a disordered segment is never reached,
        // so none of the divisions below can see a zero divisor.
        if (charge * 100 < longint'(shift_lo) * full_cap) begin
          r.segment = SEG_LOW;
          dq = (dl * x) / sl;
        end else if (charge * 100 < longint'(shift_hi) * full_cap) begin
          r.segment = SEG_MID;
          dq = dl * 65536 + ((dh - dl) * (x - sl * 65536)) / (sh - sl);
        end else begin
          r.segment = SEG_HIGH;
          dq = dh * 65536 + ((100 - dh) * (x - sh * 65536)) / (100 - sh);
        end
        v = v0 - (v0 * dq) / 65536;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        r.voltage_mv = 16'(v);
      end
      pending.push_back(r);
    endfunction

    function void check_result(cell_report_t got);
      cell_report_t e;
      if (pending.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.accepted !== e.accepted) begin
        $error("accepted: expected %0d, got %0d", e.accepted, got.accepted); errors++;
      end
      if (got.voltage_mv !== e.voltage_mv) begin
        $error("voltage_mv: expected %0d, got %0d", e.voltage_mv, got.voltage_mv); errors++;
      end
      if (got.remaining !== e.remaining) begin
        $error("remaining_hundredths: expected %0d, got %0d", e.remaining, got.remaining);
        errors++;
      end
      if (got.current_ma !== e.current_ma) begin
        $error("source_current_ma: expected %0d, got %0d", e.current_ma, got.current_ma);
        errors++;
      end
      if (got.segment !== e.segment) begin
        $error("segment: expected %0d, got %0d", e.segment, got.segment); errors++;
      end
      if (got.exhausted !== e.exhausted) begin
        $error("exhausted: expected %0d, got %0d", e.exhausted, got.exhausted); errors++;
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              s_axis_tvalid = 0;
  logic              s_axis_tready;
  // tdata: connected, load_current_ma, duration_ms, zero pad (lowest bit first)
  logic [IN_W-1:0]   s_axis_tdata = '0;
  // tuser: kind
  logic              s_axis_tuser = 0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 0;
  // tdata: accepted, voltage_mv, remaining_hundredths, source_current_ma,
  // segment, exhausted, zero pad (lowest bit first)
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  battery_cell_discharge_model dut (.*);

  always #5 clk_i = ~clk_i;

  cell_scoreboard sb = new();

  // Idle controls shared by the sender and receiver.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int recv_hold      = 0;
  int cur_max = 1000, dur_max = 250;
  longint unsigned cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off that backs the block up.
  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      m_axis_tready <= 0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor. Values read at the edge are those the handshake saw.
  always @(posedge clk_i) begin
    cell_report_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted   = m_axis_tdata[0];
      got.voltage_mv = m_axis_tdata[16:1];
      got.remaining  = m_axis_tdata[30:17];
      got.current_ma = m_axis_tdata[46:31];
      got.segment    = m_axis_tdata[48:47];
      got.exhausted  = m_axis_tdata[49];
      sb.check_result(got);
    end
  end

  // APB write: setup cycle then access cycle; pready is always high.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_cell(int cap, int v0, int sl, int sh, int dl, int dh);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_INIT_VOLT, v0);
    write_reg(REG_SHIFT_LO, sl);
    write_reg(REG_SHIFT_HI, sh);
    write_reg(REG_DROP_LO, dl);
    write_reg(REG_DROP_HI, dh);
  endtask

  // Offers one request and returns once it is taken. Valid stays high
  // into the next request unless the sender decides to idle first.
  task automatic send_request(bit kind, bit conn, logic [15:0] cur, logic [15:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_W-33){1'b0}}, dur, cur, conn};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_request(kind, conn, cur, dur);
  endtask

  // Random requests: mostly discharge steps scaled to walk through the curve,
  // with reloads, rejected steps, disconnects and full-range noise mixed in.
  task automatic send_random(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 4) send_request(1, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
      else if (r < 9) send_request(0, 1'($urandom_range(1)), 16'($urandom), 16'd0);
      else if (r < 14) send_request(0, 0, 16'($urandom), 16'($urandom_range(1, 65535)));
      else if (r < 20) send_request(0, 1, 16'($urandom), 16'($urandom));
      else send_request(0, 1, 16'($urandom_range(0, cur_max)),
                        16'($urandom_range(1, dur_max)));
    end
  endtask

  // Lets every outstanding result drain before registers change.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part on the default cell (800 mAh, 12 V).
    send_request(0, 1, 0, 1);              // fresh cell, zero current
    send_request(0, 1, 100, 0);            // zero duration is rejected
    send_request(0, 1, 65535, 2000);       // into the first segment
    send_request(0, 1, 65535, 4000);       // across the first break point
    send_request(0, 0, 65535, 65535);      // disconnected: current drops to zero
    send_request(0, 1, 60000, 30000);      // deep into the middle segment
    send_request(0, 1, 50000, 8000);       // past the second break point
    send_request(0, 0, 0, 1);
    send_request(0, 1, 65535, 65535);      // exhausts the cell
    send_request(0, 1, 1, 1);              // stays exhausted
    send_request(0, 1, 5, 0);              // rejected while exhausted
    send_request(1, 0, 0, 0);              // reload keeps the present current
    send_request(1, 1, 65535, 65535);
    send_request(0, 1, 43690, 21845);      // alternating bit patterns
    send_request(0, 1, 21845, 43690);
    send_request(1, 0, 0, 0);
    send_request(0, 1, 65535, 65535);
    drain();

    // Capacity of 1 mAh, widest curve, full-scale voltage; sender mostly idle.
    set_cell(1, 65535, 1, 99, 0, 100);
    send_idle_pct = 88; recv_stall_pct = 0;
    send_request(0, 1, 3600, 1000);        // exactly full capacity: exhausted
    send_request(1, 0, 0, 0);
    send_random(120);
    drain();

    // Largest capacity, zero voltage, disordered shifts and drops; receiver stalls.
    set_cell(65535, 0, 98, 2, 99, 1);
    send_idle_pct = 0; recv_stall_pct = 88;
    cur_max = 65535; dur_max = 65535;
    send_random(120);
    drain();

    // Capacity zero is always exhausted; drop registers above 100; both idle.
    set_cell(0, 3000, 127, 127, 127, 127);
    send_idle_pct = 34; recv_stall_pct = 34;
    send_random(40);
    drain();
    // Drops above 100 push the voltage below zero, so it saturates.
    set_cell(2, 40000, 20, 30, 100, 120);
    cur_max = 2000; dur_max = 400;
    send_random(80);
    drain();

    // Ordinary cell with a long receiver hold-off so the block backs up.
    set_cell(3, 12000, 10, 85, 5, 10);
    send_idle_pct = 0; recv_stall_pct = 0;
    cur_max = 3000; dur_max = 300;
    recv_hold = 400;
    send_random(120);
    send_idle_pct = 34; recv_stall_pct = 34;
    send_random(150);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
